// ----- rtl/self_id_sequence_checker_top_defines.svh -----
// Assertion macros for the self-ID checker assertions in sidc_checker.sv.
`ifndef SELF_ID_SEQUENCE_CHECKER_TOP_DEFINES_SVH
`define SELF_ID_SEQUENCE_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sidc_pkg.sv -----
// Types, request codes and self-ID field constants for the self-ID checker.
`timescale 1ns / 1ps
package sidc_pkg;

  localparam logic [1:0] REQ_BUS_RESET = 2'd0;
  localparam logic [1:0] REQ_SELF_ID   = 2'd1;
  localparam logic [1:0] REQ_COMPLETE  = 2'd2;

  localparam int unsigned EXT_BIT_POS     = 23;
  localparam int unsigned CONTENDER_POS   = 11;
  localparam int unsigned LINK_ACTIVE_POS = 22;
  localparam logic [4:0]  SEQ_START       = 5'd23;
  localparam logic [1:0]  PORT_PARENT     = 2'b10;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd20;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        root_flag;
    logic [5:0]  phy_id;
    logic [31:0] sid_quadlet;
  } item_t;

  // Packed so that accepted lands in bit 0 of the output tdata.
  typedef struct packed {
    logic [31:0] generation;
    logic        gave_up;
    logic        reset_request;
    logic        is_root;
    logic        is_irm;
    logic [5:0]  irm_node;
    logic        irm_found;
    logic        check_ok;
    logic [6:0]  node_total;
    logic        accepted;
  } result_t;

  // One flag per port pair (bits 2..17): set where the port is coded parent.
  function automatic logic [7:0] parent_pairs(input logic [31:0] q);
    logic [7:0] pp;
    for (int b = 0; b < 8; b++) begin
      pp[b] = (q[2*b+2 +: 2] == PORT_PARENT);
    end
    return pp;
  endfunction

endpackage

// ----- rtl/sidc_core.sv -----
// Round state and per-item evaluation of the self-ID checker.
`timescale 1ns / 1ps
module sidc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  sidc_pkg::item_t item_i,
  input  logic [7:0]      retry_limit_i,
  output sidc_pkg::result_t res_o
);
  import sidc_pkg::*;

  logic        in_reset_q, in_reset_d;
  logic [6:0]  exp_node_q, exp_node_d;
  logic [4:0]  ext_seq_q, ext_seq_d;
  logic        seq_failed_q, seq_failed_d;
  logic        parent_q, parent_d;
  logic        irm_valid_q, irm_valid_d;
  logic [5:0]  irm_id_q, irm_id_d;
  logic [7:0]  retry_q, retry_d;
  logic        root_q, root_d;
  logic [31:0] gen_q, gen_d;

  logic [31:0] q;
  logic [5:0]  id;
  logic [7:0]  pp;
  logic        ok;

  assign q  = item_i.sid_quadlet;
  assign id = q[29:24];
  assign pp = parent_pairs(q);
  assign ok = !seq_failed_q && !parent_q && (exp_node_q != 7'd0);

  always_comb begin
    in_reset_d   = in_reset_q;
    exp_node_d   = exp_node_q;
    ext_seq_d    = ext_seq_q;
    seq_failed_d = seq_failed_q;
    parent_d     = parent_q;
    irm_valid_d  = irm_valid_q;
    irm_id_d     = irm_id_q;
    retry_d      = retry_q;
    root_d       = root_q;
    gen_d        = gen_q;
    res_o        = '0;

    unique case (item_i.req_type)
      REQ_BUS_RESET: begin
        if (!in_reset_q) begin
          res_o.accepted = 1'b1;
          in_reset_d     = 1'b1;
          exp_node_d     = '0;
          ext_seq_d      = SEQ_START;
          seq_failed_d   = 1'b0;
          parent_d       = 1'b0;
          irm_valid_d    = 1'b0;
          irm_id_d       = '0;
        end
      end
      REQ_SELF_ID: begin
        if (in_reset_q) begin
          res_o.accepted = 1'b1;
          if (!seq_failed_q) begin
            if (!q[EXT_BIT_POS]) begin
              if ({1'b0, id} != exp_node_q) begin
                seq_failed_d = 1'b1;
              end else begin
                exp_node_d = exp_node_q + 7'd1;
                ext_seq_d  = '0;
                if (q[CONTENDER_POS] && q[LINK_ACTIVE_POS]) begin
                  irm_valid_d = 1'b1;
                  irm_id_d    = id;
                end
                parent_d = |pp[2:0];
              end
            end else begin
              if (exp_node_q == 7'd0 || {1'b0, id} != (exp_node_q - 7'd1) ||
                  {2'b00, q[22:20]} != ext_seq_q) begin
                seq_failed_d = 1'b1;
              end else begin
                ext_seq_d = ext_seq_q + 5'd1;
                parent_d  = parent_q || (|pp);
              end
            end
          end
        end
      end
      REQ_COMPLETE: begin
        res_o.accepted  = 1'b1;
        in_reset_d      = 1'b0;
        root_d          = item_i.root_flag;
        res_o.check_ok  = ok;
        res_o.node_total = ok ? exp_node_q : 7'd0;
        if (!ok && retry_q < retry_limit_i) begin
          retry_d             = retry_q + 8'd1;
          res_o.reset_request = 1'b1;
          // retry reopens the round at once
          in_reset_d   = 1'b1;
          exp_node_d   = '0;
          ext_seq_d    = SEQ_START;
          seq_failed_d = 1'b0;
          parent_d     = 1'b0;
          irm_valid_d  = 1'b0;
          irm_id_d     = '0;
        end else begin
          res_o.gave_up = !ok;
          res_o.is_irm  = irm_valid_q && (irm_id_q == item_i.phy_id);
          retry_d       = '0;
          gen_d         = gen_q + 32'd1;
        end
      end
      default: begin
      end
    endcase

    // completion reports the IRM of the round just closed, others the new state
    if (item_i.req_type == REQ_COMPLETE) begin
      res_o.irm_found = irm_valid_q;
      res_o.irm_node  = irm_valid_q ? irm_id_q : 6'd0;
    end else begin
      res_o.irm_found = irm_valid_d;
      res_o.irm_node  = irm_valid_d ? irm_id_d : 6'd0;
    end
    res_o.is_root    = root_d;
    res_o.generation = gen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_reset_q   <= 1'b0;
      exp_node_q   <= '0;
      ext_seq_q    <= SEQ_START;
      seq_failed_q <= 1'b0;
      parent_q     <= 1'b0;
      irm_valid_q  <= 1'b0;
      irm_id_q     <= '0;
      retry_q      <= '0;
      root_q       <= 1'b0;
      gen_q        <= '0;
    end else if (adv_i) begin
      in_reset_q   <= in_reset_d;
      exp_node_q   <= exp_node_d;
      ext_seq_q    <= ext_seq_d;
      seq_failed_q <= seq_failed_d;
      parent_q     <= parent_d;
      irm_valid_q  <= irm_valid_d;
      irm_id_q     <= irm_id_d;
      retry_q      <= retry_d;
      root_q       <= root_d;
      gen_q        <= gen_d;
    end
  end

endmodule

// ----- rtl/self_id_sequence_checker_top.sv -----
// Top level of the self-ID sequence checker: stream ports, input and result registers.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: quadlet, phy id, root flag; tuser: request
//  m_axis    out  tvalid/tready          tdata: check result
//  cfg       in   cfg_we_i (no wait)     cfg_wdata_i: retry limit
//
// One transfer in and one out per cycle while the output is not stalled; each item
// passes through the input register, then its result sits in the output register.
// Evaluation and state update are one pass of compares and flag updates.
// A stalled output holds; the input register still refills once the result
// register drains. Reset clears round state and generation and sets the retry limit (20).
`timescale 1ns / 1ps
module self_id_sequence_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] sid_quadlet, [37:32] phy_id, [38] root_flag
  input  logic [sidc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [7:1] node_total, [8] check_ok, [9] irm_found, [15:10] irm_node,
  // [16] is_irm, [17] is_root, [18] reset_request, [19] gave_up, [51:20] generation
  output logic [sidc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import sidc_pkg::*;

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    adv;
  logic    s_xfer;
  logic [7:0] retry_limit_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_q <= {s_axis_tuser, s_axis_tdata[38:0]};
    end
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      retry_limit_q <= cfg_wdata_i;
    end
  end

  sidc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .item_i        (in_q),
    .retry_limit_i (retry_limit_q),
    .res_o         (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

endmodule

// ----- rtl/sidc_checker.sv -----
// Port-level checks of the self-ID checker results, bound to the top level.
`timescale 1ns / 1ps
`include "self_id_sequence_checker_top_defines.svh"
module sidc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sidc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [6:0] nodes;
  logic       ok;
  logic       found;
  logic       irm;
  logic       retry;
  logic       gave;
  logic       stall;

  assign nodes = m_axis_tdata[7:1];
  assign ok    = m_axis_tdata[8];
  assign found = m_axis_tdata[9];
  assign irm   = m_axis_tdata[16];
  assign retry = m_axis_tdata[18];
  assign gave  = m_axis_tdata[19];
  assign stall = m_axis_tvalid && !m_axis_tready;

  // a failed round either retries or gives up, never both
  `SIDC_ASSERT_NOW(a_retry_xor_giveup, m_axis_tvalid, !(retry && gave), "retry with give-up")

  // node total is nonzero exactly when the check passed
  `SIDC_ASSERT_NOW(a_count_ok, m_axis_tvalid, ok == (nodes != 7'd0), "count vs check_ok")

  // is_irm needs a found IRM
  `SIDC_ASSERT_NOW(a_irm_found, m_axis_tvalid && irm, found, "is_irm without irm_found")

  // stalled result holds
  `SIDC_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind self_id_sequence_checker_top sidc_checker u_sidc_checker (.*);
